FILE: src/atps_pkg.sv
// ----------------------------------------------------------------------------
// atps_pkg
// shared types, codes and tone tables of the alarm tone pattern sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package atps_pkg;

  localparam int WAVE_ENTRIES_DEF = 32;
  localparam int PATTERN_COUNT    = 7;
  localparam int TICK_STEP_MS     = 10;
  localparam int SINE_LEN         = 32;
  localparam int TABLE_ROWS       = 7;

  localparam logic [11:0] DAC_CENTRE = 12'd2048;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    OP_MS_TICK = 3'd0,
    OP_SAMPLE  = 3'd1,
    OP_PLAY    = 3'd2,
    OP_BEEP    = 3'd3,
    OP_STOP    = 3'd4
  } atps_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOUND_EN   = 2'd0,
    CFG_FREQ_FLOOR = 2'd1,
    CFG_FREQ_CEIL  = 2'd2
  } atps_cfg_idx_e;

  typedef struct packed {
    logic        sound_enabled;
    logic [15:0] freq_floor;
    logic [15:0] freq_ceiling;
  } atps_cfg_t;

  typedef struct packed {
    logic        sounding;
    logic        in_on_phase;
    logic [15:0] cur_freq;
    logic [15:0] beep_duration;
    logic [15:0] beep_elapsed;
    logic [2:0]  active_pattern;
    logic [7:0]  repeats_left;
    logic [15:0] phase_timer;
    logic [11:0] dac_hold;
  } atps_state_t;

  typedef struct packed {
    logic        busy_res;
    logic [15:0] tone_freq;
    logic        tone_on;
    logic [11:0] dac_value;
  } atps_res_t;

  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [7:0]  reps;
  } atps_row_t;

  localparam logic [11:0] SINE_ROM [SINE_LEN] = '{
    12'd2048, 12'd2447, 12'd2831, 12'd3185, 12'd3496, 12'd3750, 12'd3939, 12'd4056,
    12'd4095, 12'd4056, 12'd3939, 12'd3750, 12'd3496, 12'd3185, 12'd2831, 12'd2447,
    12'd2048, 12'd1649, 12'd1265, 12'd911,  12'd600,  12'd346,  12'd157,  12'd40,
    12'd0,    12'd40,   12'd157,  12'd346,  12'd600,  12'd911,  12'd1265, 12'd1649
  };

  function automatic atps_row_t pattern_row(logic [2:0] id);
    atps_row_t r;
    case (id)
      3'd1:    r = '{freq: 16'd1000, on_ms: 16'd100, off_ms: 16'd0,   reps: 8'd1};
      3'd2:    r = '{freq: 16'd1000, on_ms: 16'd500, off_ms: 16'd0,   reps: 8'd1};
      3'd3:    r = '{freq: 16'd2000, on_ms: 16'd50,  off_ms: 16'd50,  reps: 8'd0};
      3'd4:    r = '{freq: 16'd1500, on_ms: 16'd200, off_ms: 16'd200, reps: 8'd0};
      3'd5:    r = '{freq: 16'd800,  on_ms: 16'd150, off_ms: 16'd100, reps: 8'd2};
      3'd6:    r = '{freq: 16'd1200, on_ms: 16'd150, off_ms: 16'd0,   reps: 8'd1};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/atps_update.sv
// ----------------------------------------------------------------------------
// atps_update
// next state and result of the sequencer for one event
// ----------------------------------------------------------------------------
`default_nettype none

module atps_update #(
  parameter int WaveEntries = atps_pkg::WAVE_ENTRIES_DEF,
  parameter int WaveW       = $clog2(WaveEntries)
) (
  input  atps_pkg::atps_cfg_t   cfg_i,
  input  logic [2:0]            op_i,
  input  logic [2:0]            pattern_id_i,
  input  logic [15:0]           beep_freq_i,
  input  logic [15:0]           beep_length_i,
  input  atps_pkg::atps_state_t st_i,
  input  logic [WaveW-1:0]      wave_i,
  output atps_pkg::atps_state_t st_o,
  output logic [WaveW-1:0]      wave_o,
  output atps_pkg::atps_res_t   res_o
);
  import atps_pkg::*;

  logic [11:0] wave_lut [WaveEntries];

  for (genvar g = 0; g < WaveEntries; g++) begin : g_lut
    assign wave_lut[g] = SINE_ROM[5'((g * SINE_LEN) / WaveEntries)];
  end

  function automatic logic [15:0] sat_step(logic [15:0] a);
    logic [16:0] s;
    s = {1'b0, a} + 17'(TICK_STEP_MS);
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [15:0] clamp(logic [15:0] f, logic [15:0] lo, logic [15:0] hi);
    if (f < lo) begin
      return lo;
    end else if (f > hi) begin
      return hi;
    end
    return f;
  endfunction

  atps_state_t      s;
  logic [WaveW-1:0] w;
  atps_row_t        row;
  atps_row_t        new_row;
  logic             ended;

  assign row     = pattern_row(st_i.active_pattern);
  assign new_row = pattern_row(pattern_id_i);

  always_comb begin
    s     = st_i;
    w     = wave_i;
    ended = 1'b0;
    case (atps_op_e'(op_i))
      OP_STOP: begin
        s.sounding       = 1'b0;
        s.active_pattern = '0;
        s.dac_hold       = DAC_CENTRE;
      end
      OP_MS_TICK: begin
        if (cfg_i.sound_enabled) begin
          if (s.active_pattern != '0) begin
            s.phase_timer = sat_step(s.phase_timer);
            if (s.in_on_phase) begin
              if (s.phase_timer >= row.on_ms) begin
                s.phase_timer = '0;
                if (row.off_ms != '0) begin
                  s.in_on_phase = 1'b0;
                  s.sounding    = 1'b0;
                  s.dac_hold    = DAC_CENTRE;
                end else if (s.repeats_left != '0) begin
                  s.repeats_left = s.repeats_left - 8'd1;
                  if (s.repeats_left == '0) begin
                    s.sounding       = 1'b0;
                    s.active_pattern = '0;
                    s.dac_hold       = DAC_CENTRE;
                  end
                end
              end
            end else if (s.phase_timer >= row.off_ms) begin
              s.phase_timer = '0;
              if (s.repeats_left != '0) begin
                s.repeats_left = s.repeats_left - 8'd1;
                if (s.repeats_left == '0) begin
                  s.sounding       = 1'b0;
                  s.active_pattern = '0;
                  s.dac_hold       = DAC_CENTRE;
                  ended            = 1'b1;
                end
              end
              if (!ended) begin
                s.in_on_phase   = 1'b1;
                s.cur_freq      = clamp(row.freq, cfg_i.freq_floor, cfg_i.freq_ceiling);
                s.beep_duration = row.on_ms;
                s.beep_elapsed  = '0;
                s.sounding      = 1'b1;
              end
            end
          end
          // beep timing, for single beeps and pattern on phases alike
          if (s.sounding && s.beep_duration != '0) begin
            s.beep_elapsed = sat_step(s.beep_elapsed);
            if (s.beep_elapsed >= s.beep_duration) begin
              s.sounding = 1'b0;
              s.dac_hold = DAC_CENTRE;
            end
          end
        end
      end
      OP_SAMPLE: begin
        if (cfg_i.sound_enabled) begin
          if (s.sounding) begin
            s.dac_hold = wave_lut[wave_i];
            w = (wave_i == WaveW'(WaveEntries - 1)) ? '0 : wave_i + WaveW'(1);
          end else begin
            s.dac_hold = DAC_CENTRE;
          end
        end
      end
      OP_PLAY: begin
        if (cfg_i.sound_enabled) begin
          if (pattern_id_i == '0) begin
            s.sounding       = 1'b0;
            s.active_pattern = '0;
            s.dac_hold       = DAC_CENTRE;
          end else if (int'(pattern_id_i) < TABLE_ROWS &&
                       int'(pattern_id_i) < PATTERN_COUNT) begin
            s.active_pattern = pattern_id_i;
            s.repeats_left   = new_row.reps;
            s.phase_timer    = '0;
            s.in_on_phase    = 1'b1;
            s.cur_freq       = clamp(new_row.freq, cfg_i.freq_floor, cfg_i.freq_ceiling);
            s.beep_duration  = new_row.on_ms;
            s.beep_elapsed   = '0;
            s.sounding       = 1'b1;
          end
        end
      end
      OP_BEEP: begin
        if (cfg_i.sound_enabled) begin
          s.cur_freq      = clamp(beep_freq_i, cfg_i.freq_floor, cfg_i.freq_ceiling);
          s.beep_duration = beep_length_i;
          s.beep_elapsed  = '0;
          s.sounding      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign st_o   = s;
  assign wave_o = w;

  assign res_o.dac_value = s.dac_hold;
  assign res_o.tone_on   = s.sounding;
  assign res_o.tone_freq = s.sounding ? s.cur_freq : '0;
  assign res_o.busy_res  = s.sounding || (s.active_pattern != '0);

endmodule

`default_nettype wire

FILE: src/alarm_tone_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// alarm_tone_pattern_sequencer
// warning tone sequencer with pattern table, beep timer and sine output
// ----------------------------------------------------------------------------
// Events enter on the s_axis channel: tuser carries the event kind (ms tick,
// sample tick, play pattern, beep, stop), tdata the pattern id, beep
// frequency and beep length. Each event gives exactly one result on m_axis:
// DAC code, tone on flag, clamped tone frequency and busy flag.
// The cfg channel writes sound enable and the frequency clamp bounds; it is
// always ready; the user must write it only while no event is in flight,
// which the block does not enforce. Events pass through the input register,
// then the state update and the result register. Throughput is one event
// per cycle while results are taken, set by the single-pass state update.
// While the receiver stalls, the result register holds and one more event
// can wait in the input register; after that s_axis_tready drops.
// Reset (rst_ni low) silences the tone, clears the pattern and timers, sets
// the DAC code to 2048 and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_tone_pattern_sequencer #(
  parameter int WaveEntries = atps_pkg::WAVE_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: pattern_id[2:0], beep_freq[18:3], beep_length[34:19]
  input  logic [atps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: op[2:0]
  input  logic [2:0]                        s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: dac_value[11:0], tone_on[12], tone_freq[28:13], busy_res[29]
  output logic [atps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [atps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [atps_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import atps_pkg::*;

  localparam int WaveW = $clog2(WaveEntries);

  localparam atps_state_t StateReset = '{dac_hold: DAC_CENTRE, default: '0};

  atps_cfg_t        cfg_q;
  atps_state_t      state_q, state_d;
  logic [WaveW-1:0] wave_q, wave_d;
  atps_res_t        res_d;

  logic             in_valid_q;
  logic [2:0]       in_op_q;
  logic [2:0]       in_pid_q;
  logic [15:0]      in_freq_q;
  logic [15:0]      in_len_q;

  logic             out_valid_q;
  atps_res_t        out_res_q;

  logic             advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sound_enabled <= 1'b1;
      cfg_q.freq_floor    <= 16'd100;
      cfg_q.freq_ceiling  <= 16'd10000;
    end else if (cfg_valid_i) begin
      case (atps_cfg_idx_e'(cfg_index_i))
        CFG_SOUND_EN:   cfg_q.sound_enabled <= cfg_data_i[0];
        CFG_FREQ_FLOOR: cfg_q.freq_floor    <= cfg_data_i;
        CFG_FREQ_CEIL:  cfg_q.freq_ceiling  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser;
      in_pid_q  <= s_axis_tdata[2:0];
      in_freq_q <= s_axis_tdata[18:3];
      in_len_q  <= s_axis_tdata[34:19];
    end
  end

  atps_update #(
    .WaveEntries (WaveEntries),
    .WaveW       (WaveW)
  ) u_update (
    .cfg_i         (cfg_q),
    .op_i          (in_op_q),
    .pattern_id_i  (in_pid_q),
    .beep_freq_i   (in_freq_q),
    .beep_length_i (in_len_q),
    .st_i          (state_q),
    .wave_i        (wave_q),
    .st_o          (state_d),
    .wave_o        (wave_d),
    .res_o         (res_d)
  );

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
      wave_q  <= '0;
    end else if (advance) begin
      state_q <= state_d;
      wave_q  <= wave_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - $bits(atps_res_t)){1'b0}}, out_res_q};

`ifndef ASSERT_OFF
  a_freq_zero_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_res_q.tone_on |-> out_res_q.tone_freq == '0)
    else $error("tone frequency reported while silent");

  a_busy_covers_tone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.tone_on |-> out_res_q.busy_res)
    else $error("tone on without busy");

  a_wave_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(wave_q) < WaveEntries)
    else $error("wave index out of range");

  a_disabled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !cfg_q.sound_enabled && in_op_q != OP_STOP |=>
      state_q == $past(state_q) && wave_q == $past(wave_q))
    else $error("state changed while sound disabled");

  a_stop_silences: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_op_q == OP_STOP |=>
      !state_q.sounding && state_q.active_pattern == '0 && state_q.dac_hold == DAC_CENTRE)
    else $error("stop left the tone running");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tone_sequencer_checker.sv
// ----------------------------------------------------------------------------
// tone_sequencer_checker
// watches the event, result and register channels of the tone sequencer,
// keeps its own copy of the tone, pattern and sine state, works out the
// result of every accepted event and compares it field by field with the
// result transfers in order
// ----------------------------------------------------------------------------
module tone_sequencer_checker
  import atps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_DATA_W-1:0]  ev_data_i,
  input  logic [2:0]            ev_op_i,
  input  logic                  ev_valid_i,
  input  logic                  ev_ready_i,
  input  logic [OUT_DATA_W-1:0] res_data_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o
);

  localparam int          TICK_MS  = 10;
  localparam int          PAT_ROWS = 7;
  localparam logic [11:0] SILENT   = 12'd2048;

  localparam logic [15:0] PAT_FREQ [PAT_ROWS] =
    '{16'd0, 16'd1000, 16'd1000, 16'd2000, 16'd1500, 16'd800, 16'd1200};
  localparam logic [15:0] PAT_ON_MS [PAT_ROWS] =
    '{16'd0, 16'd100, 16'd500, 16'd50, 16'd200, 16'd150, 16'd150};
  localparam logic [15:0] PAT_OFF_MS [PAT_ROWS] =
    '{16'd0, 16'd0, 16'd0, 16'd50, 16'd200, 16'd100, 16'd0};
  localparam logic [7:0] PAT_REPS [PAT_ROWS] =
    '{8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd2, 8'd1};

  localparam logic [11:0] SINE_CODES [32] = '{
    12'd2048, 12'd2447, 12'd2831, 12'd3185, 12'd3496, 12'd3750, 12'd3939, 12'd4056,
    12'd4095, 12'd4056, 12'd3939, 12'd3750, 12'd3496, 12'd3185, 12'd2831, 12'd2447,
    12'd2048, 12'd1649, 12'd1265, 12'd911,  12'd600,  12'd346,  12'd157,  12'd40,
    12'd0,    12'd40,   12'd157,  12'd346,  12'd600,  12'd911,  12'd1265, 12'd1649
  };

  logic        en_q;
  logic [15:0] floor_q, ceil_q;
  logic        sounding, on_phase;
  logic [15:0] cur_freq, beep_len, beep_elapsed, phase_ms;
  logic [2:0]  active_pat;
  logic [7:0]  reps_left;
  logic [4:0]  wave_pos;
  logic [11:0] dac_code;

  atps_res_t   tone_expect_q [$];
  atps_res_t   got, want;
  int unsigned mismatches, checked;

  function automatic logic [15:0] add_tick(logic [15:0] a);
    logic [16:0] s;
    s = {1'b0, a} + 17'(TICK_MS);
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  task automatic silence();
    sounding   = 1'b0;
    active_pat = '0;
    dac_code   = SILENT;
  endtask

  task automatic tone_start(input logic [15:0] f, input logic [15:0] len);
    if (f < floor_q) begin
      f = floor_q;
    end else if (f > ceil_q) begin
      f = ceil_q;
    end
    cur_freq     = f;
    beep_len     = len;
    beep_elapsed = '0;
    sounding     = 1'b1;
  endtask

  task automatic pattern_step();
    phase_ms = add_tick(phase_ms);
    if (on_phase) begin
      if (phase_ms >= PAT_ON_MS[active_pat]) begin
        phase_ms = '0;
        if (PAT_OFF_MS[active_pat] != 0) begin
          on_phase = 1'b0;
          sounding = 1'b0;
          dac_code = SILENT;
        end else if (reps_left != 0) begin
          reps_left--;
          if (reps_left == 0) silence();
        end
      end
    end else if (phase_ms >= PAT_OFF_MS[active_pat]) begin
      phase_ms = '0;
      if (reps_left != 0) begin
        reps_left--;
        if (reps_left == 0) begin
          silence();
          return;
        end
      end
      on_phase = 1'b1;
      tone_start(PAT_FREQ[active_pat], PAT_ON_MS[active_pat]);
    end
  endtask

  task automatic ms_step();
    if (active_pat != 0) pattern_step();
    if (!sounding || beep_len == 0) return;
    beep_elapsed = add_tick(beep_elapsed);
    if (beep_elapsed >= beep_len) begin
      if (active_pat == 0) begin
        silence();
      end else begin
        sounding = 1'b0;
        dac_code = SILENT;
      end
    end
  endtask

  task automatic wave_step();
    if (sounding) begin
      dac_code = SINE_CODES[wave_pos];
      wave_pos = wave_pos + 5'd1;
    end else begin
      dac_code = SILENT;
    end
  endtask

  task automatic apply_event(input logic [2:0] op, input logic [2:0] pid,
                             input logic [15:0] bf, input logic [15:0] bl);
    if (op == OP_STOP) begin
      silence();
    end else if (en_q) begin
      case (op)
        OP_MS_TICK: ms_step();
        OP_SAMPLE:  wave_step();
        OP_PLAY: begin
          if (pid == 0) begin
            silence();
          end else if (pid < PAT_ROWS) begin
            active_pat = pid;
            reps_left  = PAT_REPS[pid];
            phase_ms   = '0;
            on_phase   = 1'b1;
            tone_start(PAT_FREQ[pid], PAT_ON_MS[pid]);
          end
        end
        OP_BEEP: tone_start(bf, bl);
        default: ;
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q         = 1'b1;
      floor_q      = 16'd100;
      ceil_q       = 16'd10000;
      sounding     = 1'b0;
      on_phase     = 1'b0;
      cur_freq     = '0;
      beep_len     = '0;
      beep_elapsed = '0;
      active_pat   = '0;
      reps_left    = '0;
      phase_ms     = '0;
      wave_pos     = '0;
      dac_code     = SILENT;
      tone_expect_q.delete();
      mismatches   = 0;
      checked      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SOUND_EN:   en_q = cfg_data_i[0];
          CFG_FREQ_FLOOR: floor_q = cfg_data_i;
          CFG_FREQ_CEIL:  ceil_q = cfg_data_i;
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        got = atps_res_t'(res_data_i[$bits(atps_res_t)-1:0]);
        checked++;
        if (tone_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d with no event pending: dac=%0d on=%0b freq=%0d busy=%0b",
                     checked, got.dac_value, got.tone_on, got.tone_freq, got.busy_res);
        end else begin
          want = tone_expect_q.pop_front();
          if (got.dac_value !== want.dac_value || got.tone_on !== want.tone_on ||
              got.tone_freq !== want.tone_freq || got.busy_res !== want.busy_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: expected dac=%0d on=%0b freq=%0d busy=%0b",
                       checked, want.dac_value, want.tone_on, want.tone_freq,
                       want.busy_res);
              $display("  got dac=%0d on=%0b freq=%0d busy=%0b",
                       got.dac_value, got.tone_on, got.tone_freq, got.busy_res);
            end
          end
        end
      end
      if (ev_valid_i && ev_ready_i) begin
        apply_event(ev_op_i, ev_data_i[2:0], ev_data_i[18:3], ev_data_i[34:19]);
        want.dac_value = dac_code;
        want.tone_on   = sounding;
        want.tone_freq = sounding ? cur_freq : 16'd0;
        want.busy_res  = sounding || active_pat != 0;
        tone_expect_q.push_back(want);
      end
      fail_count_o <= mismatches;
      pending_o    <= tone_expect_q.size();
      checked_o    <= checked;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the alarm tone pattern sequencer
// ----------------------------------------------------------------------------
// A short directed run hits silent output, clamping, endless and timed beeps,
// unused event codes, the stop and unknown pattern ids and a beep over a
// pattern. Random runs then play patterns and beeps followed by bursts of
// ticks, under several clamp settings (inverted and equal bounds included)
// and with sound disabled, while both sides idle at random and the result
// side holds off long enough to stall the input. The checker beside the
// block predicts every result.
// ----------------------------------------------------------------------------
module testbench;
  import atps_pkg::*;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [2:0]            s_axis_tuser  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  int unsigned fail_count, pending, checked;
  int unsigned src_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned events_sent  = 0;
  int unsigned reg_writes   = 0;
  bit          hold_req     = 1'b0;

  alarm_tone_pattern_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  tone_sequencer_checker tone_watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_data_i    (s_axis_tdata),
    .ev_op_i      (s_axis_tuser),
    .ev_valid_i   (s_axis_tvalid),
    .ev_ready_i   (s_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  // result side: random back pressure, or a long counted hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic post_event(input logic [2:0] op, input logic [2:0] pid,
                            input logic [15:0] freq, input logic [15:0] len);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_DATA_W - 35){1'b0}}, len, freq, pid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    events_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic en, input logic [15:0] lo, input logic [15:0] hi);
    atps_cfg_idx_e idx [3];
    logic [15:0]   val [3];
    int            k;
    idx = '{CFG_SOUND_EN, CFG_FREQ_FLOOR, CFG_FREQ_CEIL};
    val = '{{15'($urandom), en}, lo, hi};
    for (k = 0; k < 3; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      reg_writes++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_freq();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 12000));
      2:       return 16'($urandom_range(0, 200));
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_len();
    case ($urandom_range(3))
      0:       return 16'h0000;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(1, 400));
    endcase
  endfunction

  // mostly ticks that drive the pattern and beep timers, some other events
  task automatic post_filler();
    int         r;
    logic [2:0] op;
    r = $urandom_range(99);
    if (r < 55)      op = OP_MS_TICK;
    else if (r < 88) op = OP_SAMPLE;
    else if (r < 92) op = OP_BEEP;
    else if (r < 95) op = OP_STOP;
    else if (r < 98) op = OP_PLAY;
    else             op = 3'($urandom_range(int'(OP_STOP) + 1, 7));
    post_event(op, 3'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic run_segment(input int unsigned target, input bit with_hold);
    int unsigned start;
    int unsigned burst;
    int          kind;
    start = events_sent;
    while (events_sent - start < target) begin
      if (with_hold && events_sent - start >= target / 2) begin
        hold_req  = 1'b1;
        with_hold = 1'b0;
      end
      kind = $urandom_range(9);
      if (kind < 5) begin
        post_event(OP_PLAY, 3'($urandom_range(1, 6)), 16'($urandom), 16'($urandom));
        burst = $urandom_range(5, 70);
      end else if (kind < 8) begin
        post_event(OP_BEEP, 3'($urandom), pick_freq(), pick_len());
        burst = $urandom_range(2, 40);
      end else begin
        burst = $urandom_range(1, 8);
      end
      repeat (burst) begin
        if (kind < 8) post_filler();
        else post_event(3'($urandom), 3'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    logic [15:0] lo, hi;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under reset settings
    post_event(OP_SAMPLE, 3'd0, 16'h0000, 16'h0000);
    post_event(OP_MS_TICK, 3'h7, 16'hFFFF, 16'hFFFF);
    post_event(OP_BEEP, 3'd0, 16'h0000, 16'h0000);
    repeat (2) post_event(OP_SAMPLE, 3'($urandom), 16'($urandom), 16'($urandom));
    post_event(OP_MS_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
    post_event(OP_BEEP, 3'($urandom), 16'hFFFF, 16'd30);
    repeat (3) post_event(OP_MS_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
    for (int k = int'(OP_STOP) + 1; k < 8; k++)
      post_event(3'(k), 3'($urandom), 16'($urandom), 16'($urandom));
    post_event(OP_PLAY, 3'd7, 16'($urandom), 16'($urandom));
    post_event(OP_PLAY, 3'd3, 16'($urandom), 16'($urandom));
    post_event(OP_BEEP, 3'($urandom), 16'd500, 16'd0);
    repeat (6) post_event(OP_MS_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
    post_event(OP_SAMPLE, 3'($urandom), 16'($urandom), 16'($urandom));
    post_event(OP_PLAY, 3'd0, 16'($urandom), 16'($urandom));
    post_event(OP_PLAY, 3'd5, 16'($urandom), 16'($urandom));
    post_event(OP_STOP, 3'($urandom), 16'($urandom), 16'($urandom));
    post_event(OP_SAMPLE, 3'($urandom), 16'($urandom), 16'($urandom));
    settle();

    src_idle_pct = 27;
    rcv_idle_pct = 82;
    program_regs(1'b1, 16'd1, 16'hFFFF);
    run_segment(200, 1'b1);
    settle();
    program_regs(1'b1, 16'd9000, 16'd700);
    run_segment(200, 1'b0);
    settle();

    src_idle_pct = 82;
    rcv_idle_pct = 27;
    program_regs(1'b0, 16'hFFFF, 16'd1);
    run_segment(60, 1'b0);
    settle();
    lo = 16'($urandom_range(1, 2000));
    hi = 16'($urandom_range(2000, 65535));
    program_regs(1'b1, lo, hi);
    run_segment(200, 1'b0);
    settle();

    src_idle_pct = 0;
    rcv_idle_pct = 0;
    program_regs(1'b1, 16'd100, 16'd10000);
    run_segment(250, 1'b1);
    settle();
    lo = 16'($urandom_range(1, 65535));
    program_regs(1'b1, lo, lo);
    run_segment(200, 1'b0);
    settle();
    repeat (8) @(posedge clk_i);

    $display("run covered %0d events and %0d results over %0d register writes,",
             events_sent, checked, reg_writes);
    $display("including long result stalls, odd clamp bounds and disabled sound");
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
